// ----- rtl/cau_pkg.sv -----
// Package for the complex arithmetic unit.
// Holds the command and status codes shared by the core.
// No dependencies.
`default_nettype none

package cau_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_SAT     = 2'd1,
    STS_DIVZERO = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/complex_arithmetic_unit_core.sv -----
// Complex arithmetic unit core: add, subtract, multiply and divide of complex
// signed fixed-point words, fully pipelined, with saturation and status.
// Depends on cau_pkg.
//
//   channel  dir  tdata (low bit up)            tuser
//   s_axis   in   a_re, a_im, b_re, b_im        command
//   m_axis   out  res_re, res_im                status
//
// A word passes from input to output through the stages of products, sums,
// sign and scaling, then one restoring-division step per quotient bit
// (DATA_WIDTH + 1 steps), then the saturation register. One word is accepted
// every cycle while the output is not held. Reset clears all valid bits. The
// whole pipeline holds while a result waits at the output and m_axis_tready is low.
`default_nettype none

module complex_arithmetic_unit_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // a_re, a_im, b_re, b_im, zero padded to whole bytes.
  input  wire  [((4*DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  // command.
  input  wire  [1:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // res_re, res_im, zero padded to whole bytes.
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  // status.
  output logic [1:0]                            m_axis_tuser
);

  localparam int W   = DATA_WIDTH;
  localparam int PW  = 2 * W;
  localparam int QW  = W + 1;
  localparam int DVW = PW + FRAC_BITS;
  localparam int OTW = ((2*W+7)/8)*8;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [W-1:0] in_ar, in_ai, in_br, in_bi;
  assign in_ar = s_axis_tdata[W-1:0];
  assign in_ai = s_axis_tdata[2*W-1:W];
  assign in_br = s_axis_tdata[3*W-1:2*W];
  assign in_bi = s_axis_tdata[4*W-1:3*W];

  // Stage 1: products and add/subtract.
  logic                 v1;
  cau_pkg::cmd_t        cmd1;
  logic                 zero1;
  logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri, p_bb, p_cc;
  logic signed [W:0]    as_re, as_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
    if (en) begin
      cmd1  <= cau_pkg::cmd_t'(s_axis_tuser);
      zero1 <= (in_br == '0) && (in_bi == '0);
      p_rr  <= PW'(in_ar) * PW'(in_br);
      p_ii  <= PW'(in_ai) * PW'(in_bi);
      p_ir  <= PW'(in_ai) * PW'(in_br);
      p_ri  <= PW'(in_ar) * PW'(in_bi);
      p_bb  <= PW'(in_br) * PW'(in_br);
      p_cc  <= PW'(in_bi) * PW'(in_bi);
      if (cau_pkg::cmd_t'(s_axis_tuser) == cau_pkg::CMD_SUB) begin
        as_re <= (W+1)'(in_ar) - (W+1)'(in_br);
        as_im <= (W+1)'(in_ai) - (W+1)'(in_bi);
      end else begin
        as_re <= (W+1)'(in_ar) + (W+1)'(in_br);
        as_im <= (W+1)'(in_ai) + (W+1)'(in_bi);
      end
    end
  end

  // Stage 2: sums of products and divisor magnitude.
  logic                 v2;
  cau_pkg::cmd_t        cmd2;
  logic                 zero2;
  logic signed [PW:0]   sum_re, sum_im;
  logic [PW-1:0]        den2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      cmd2  <= cmd1;
      zero2 <= zero1;
      den2  <= PW'(p_bb) + PW'(p_cc);
      case (cmd1)
        cau_pkg::CMD_MUL: begin
          sum_re <= (PW+1)'(p_rr) - (PW+1)'(p_ii);
          sum_im <= (PW+1)'(p_ir) + (PW+1)'(p_ri);
        end
        cau_pkg::CMD_DIV: begin
          sum_re <= (PW+1)'(p_rr) + (PW+1)'(p_ii);
          sum_im <= (PW+1)'(p_ir) - (PW+1)'(p_ri);
        end
        default: begin
          sum_re <= (PW+1)'(as_re);
          sum_im <= (PW+1)'(as_im);
        end
      endcase
    end
  end

  // Stage 3: sign and magnitude.
  logic                 v3;
  cau_pkg::cmd_t        cmd3;
  logic                 zero3;
  logic [PW-1:0]        den3;
  logic                 neg3_re, neg3_im;
  logic [PW-1:0]        mag3_re, mag3_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      cmd3    <= cmd2;
      zero3   <= zero2;
      den3    <= den2;
      neg3_re <= sum_re[PW];
      neg3_im <= sum_im[PW];
      mag3_re <= sum_re[PW] ? PW'(-sum_re) : PW'(sum_re);
      mag3_im <= sum_im[PW] ? PW'(-sum_im) : PW'(sum_im);
    end
  end

  // Stage 4 feeds the division chain; index k holds the word after k steps.
  logic                 dv   [QW+1];
  cau_pkg::cmd_t        dcmd [QW+1];
  logic                 dzero[QW+1];
  logic [PW-1:0]        dden [QW+1];
  logic                 dneg_re[QW+1], dneg_im[QW+1];
  logic                 dovf_re[QW+1], dovf_im[QW+1];
  logic [PW-1:0]        drem_re[QW+1], drem_im[QW+1];
  logic [QW-1:0]        dlo_re [QW+1], dlo_im [QW+1];
  logic [QW-1:0]        dq_re  [QW+1], dq_im  [QW+1];

  logic [DVW-1:0] dvd_re, dvd_im;
  logic [PW-1:0]  sh_re, sh_im;
  logic [PW-1:0]  hi_re, hi_im;
  assign dvd_re = DVW'(mag3_re) << FRAC_BITS;
  assign dvd_im = DVW'(mag3_im) << FRAC_BITS;
  assign hi_re  = PW'(dvd_re[DVW-1:QW]);
  assign hi_im  = PW'(dvd_im[DVW-1:QW]);
  assign sh_re  = (cmd3 == cau_pkg::CMD_MUL) ? (mag3_re >> FRAC_BITS) : mag3_re;
  assign sh_im  = (cmd3 == cau_pkg::CMD_MUL) ? (mag3_im >> FRAC_BITS) : mag3_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v3;
    end
    if (en) begin
      dcmd[0]    <= cmd3;
      dzero[0]   <= zero3;
      dden[0]    <= den3;
      dneg_re[0] <= neg3_re;
      dneg_im[0] <= neg3_im;
      drem_re[0] <= hi_re;
      drem_im[0] <= hi_im;
      dlo_re[0]  <= dvd_re[QW-1:0];
      dlo_im[0]  <= dvd_im[QW-1:0];
      if (cmd3 == cau_pkg::CMD_DIV) begin
        dq_re[0]   <= '0;
        dq_im[0]   <= '0;
        dovf_re[0] <= hi_re >= den3;
        dovf_im[0] <= hi_im >= den3;
      end else begin
        dq_re[0]   <= sh_re[QW-1:0];
        dq_im[0]   <= sh_im[QW-1:0];
        dovf_re[0] <= (sh_re >> QW) != '0;
        dovf_im[0] <= (sh_im >> QW) != '0;
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [PW:0] tr_re, tr_im;
    logic        ge_re, ge_im, act;
    assign tr_re = {drem_re[k], dlo_re[k][QW-1]};
    assign tr_im = {drem_im[k], dlo_im[k][QW-1]};
    assign ge_re = tr_re >= {1'b0, dden[k]};
    assign ge_im = tr_im >= {1'b0, dden[k]};
    assign act   = (dcmd[k] == cau_pkg::CMD_DIV) && !dzero[k];

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
      if (en) begin
        dcmd[k+1]    <= dcmd[k];
        dzero[k+1]   <= dzero[k];
        dden[k+1]    <= dden[k];
        dneg_re[k+1] <= dneg_re[k];
        dneg_im[k+1] <= dneg_im[k];
        dovf_re[k+1] <= dovf_re[k];
        dovf_im[k+1] <= dovf_im[k];
        dlo_re[k+1]  <= dlo_re[k] << 1;
        dlo_im[k+1]  <= dlo_im[k] << 1;
        if (act) begin
          drem_re[k+1] <= ge_re ? PW'(tr_re - {1'b0, dden[k]}) : PW'(tr_re);
          drem_im[k+1] <= ge_im ? PW'(tr_im - {1'b0, dden[k]}) : PW'(tr_im);
          dq_re[k+1]   <= {dq_re[k][QW-2:0], ge_re};
          dq_im[k+1]   <= {dq_im[k][QW-2:0], ge_im};
        end else begin
          drem_re[k+1] <= drem_re[k];
          drem_im[k+1] <= drem_im[k];
          dq_re[k+1]   <= dq_re[k];
          dq_im[k+1]   <= dq_im[k];
        end
      end
    end
  end

  // Output stage: saturation, sign and status.
  logic [QW-1:0] lim_re, lim_im;
  logic          sat_re, sat_im;
  logic [W-1:0]  fin_re, fin_im;
  assign lim_re = dneg_re[QW] ? (QW'(1) << (W-1)) : ((QW'(1) << (W-1)) - QW'(1));
  assign lim_im = dneg_im[QW] ? (QW'(1) << (W-1)) : ((QW'(1) << (W-1)) - QW'(1));
  assign sat_re = dovf_re[QW] || (dq_re[QW] > lim_re);
  assign sat_im = dovf_im[QW] || (dq_im[QW] > lim_im);

  always_comb begin
    fin_re = sat_re ? W'(lim_re) : W'(dq_re[QW]);
    fin_im = sat_im ? W'(lim_im) : W'(dq_im[QW]);
    if (dneg_re[QW]) begin
      fin_re = -fin_re;
    end
    if (dneg_im[QW]) begin
      fin_im = -fin_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv[QW];
    end
    if (en) begin
      if (dcmd[QW] == cau_pkg::CMD_DIV && dzero[QW]) begin
        m_axis_tdata <= '0;
        m_axis_tuser <= cau_pkg::STS_DIVZERO;
      end else begin
        m_axis_tdata <= OTW'({fin_im, fin_re});
        m_axis_tuser <= (sat_re || sat_im) ? cau_pkg::STS_SAT : cau_pkg::STS_OK;
      end
    end
  end

endmodule

`default_nettype wire
